// ----- rtl/srgb_to_cie_xy_core_macros.svh -----
// Assertion macros for the chromaticity core.
`ifndef SRGB_TO_CIE_XY_CORE_MACROS_SVH
`define SRGB_TO_CIE_XY_CORE_MACROS_SVH

// ante holds at an edge -> cons holds at the same edge
`define SXY_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sxy implication check failed");

// cond holds at every edge out of reset
`define SXY_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sxy invariant check failed");

`endif

// ----- rtl/sxy_pkg.sv -----
package sxy_pkg;

    localparam int LIN_W   = 16;
    localparam int COEF_W  = 16;
    localparam int PROD_W  = LIN_W + COEF_W;
    localparam int XYZ_W   = PROD_W + 2;
    localparam int NUM_W   = XYZ_W + 16;
    localparam int Q_W     = 16;
    localparam int CH_W    = 8;
    localparam int DIV_LAT = Q_W;
    localparam int MAT_LAT = 4;

    localparam logic [Q_W-1:0] XY_MAX        = 16'd65279;
    localparam logic [15:0]    WHITE_X_RESET = 16'd20413;
    localparam logic [15:0]    WHITE_Y_RESET = 16'd21477;

    localparam logic [1:0] REG_WHITE_X = 2'd0;
    localparam logic [1:0] REG_WHITE_Y = 2'd1;

    typedef logic [LIN_W-1:0] lin_t;
    typedef lin_t [255:0] lut_t;
    typedef logic [COEF_W-1:0] coef_t;

    function automatic coef_t coef_of(input longint e4);
        longint c;
        c = ((e4 << COEF_W) + 5000) / 10000;
        return coef_t'(c);
    endfunction

    localparam coef_t C_XR = coef_of(4124);
    localparam coef_t C_XG = coef_of(3576);
    localparam coef_t C_XB = coef_of(1805);
    localparam coef_t C_YR = coef_of(2126);
    localparam coef_t C_YG = coef_of(7152);
    localparam coef_t C_YB = coef_of(722);
    localparam coef_t C_ZR = coef_of(193);
    localparam coef_t C_ZG = coef_of(1192);
    localparam coef_t C_ZB = coef_of(9505);

    // sRGB decode, linear scaled to 2^LIN_W - 1, rounded half up
    function automatic lut_t build_lut();
        lut_t   t;
        real    s;
        real    a;
        real    l;
        longint scale;
        longint e;
        scale = (longint'(1) << LIN_W) - 1;
        s = real'(scale);
        for (int v = 0; v < 256; v++)
        begin
            if (v <= 10)
            begin
                e = (20 * scale * v + 32946) / 65892;
            end
            else
            begin
                a = (real'(v) / 255.0 + 0.055) / 1.055;
                l = a ** 2.4;
                e = longint'($floor(l * s + 0.5));
            end
            t[v] = lin_t'(e);
        end
        return t;
    endfunction

    localparam lut_t GAMMA_LUT = build_lut();

endpackage

// ----- rtl/sxy_matrix.sv -----
module sxy_matrix
(
    input  logic                          clk,
    input  logic                          ce,
    input  logic [sxy_pkg::CH_W-1:0]      red,
    input  logic [sxy_pkg::CH_W-1:0]      green,
    input  logic [sxy_pkg::CH_W-1:0]      blue,
    output logic [sxy_pkg::NUM_W-1:0]     num_x,
    output logic [sxy_pkg::NUM_W-1:0]     num_y,
    output logic [sxy_pkg::XYZ_W-1:0]     sum
);

    sxy_pkg::lin_t                      lin_r_reg, lin_g_reg, lin_b_reg;
    logic [sxy_pkg::PROD_W-1:0]         prod_reg [9];
    logic [sxy_pkg::XYZ_W-1:0]          x_reg, y_reg, z_reg;
    logic [sxy_pkg::NUM_W-1:0]          num_x_reg, num_y_reg;
    logic [sxy_pkg::XYZ_W-1:0]          sum_reg;
    logic [sxy_pkg::NUM_W-1:0]          x_ext, y_ext;

    assign x_ext = sxy_pkg::NUM_W'(x_reg);
    assign y_ext = sxy_pkg::NUM_W'(y_reg);

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            lin_r_reg <= sxy_pkg::GAMMA_LUT[red];
            lin_g_reg <= sxy_pkg::GAMMA_LUT[green];
            lin_b_reg <= sxy_pkg::GAMMA_LUT[blue];

            prod_reg[0] <= lin_r_reg * sxy_pkg::C_XR;
            prod_reg[1] <= lin_g_reg * sxy_pkg::C_XG;
            prod_reg[2] <= lin_b_reg * sxy_pkg::C_XB;
            prod_reg[3] <= lin_r_reg * sxy_pkg::C_YR;
            prod_reg[4] <= lin_g_reg * sxy_pkg::C_YG;
            prod_reg[5] <= lin_b_reg * sxy_pkg::C_YB;
            prod_reg[6] <= lin_r_reg * sxy_pkg::C_ZR;
            prod_reg[7] <= lin_g_reg * sxy_pkg::C_ZG;
            prod_reg[8] <= lin_b_reg * sxy_pkg::C_ZB;

            x_reg <= sxy_pkg::XYZ_W'(prod_reg[0]) + sxy_pkg::XYZ_W'(prod_reg[1])
                   + sxy_pkg::XYZ_W'(prod_reg[2]);
            y_reg <= sxy_pkg::XYZ_W'(prod_reg[3]) + sxy_pkg::XYZ_W'(prod_reg[4])
                   + sxy_pkg::XYZ_W'(prod_reg[5]);
            z_reg <= sxy_pkg::XYZ_W'(prod_reg[6]) + sxy_pkg::XYZ_W'(prod_reg[7])
                   + sxy_pkg::XYZ_W'(prod_reg[8]);

            // part * 65279 = (part << 16) - part - (part << 8)
            num_x_reg <= (x_ext << 16) - (x_ext << 8) - x_ext;
            num_y_reg <= (y_ext << 16) - (y_ext << 8) - y_ext;
            sum_reg   <= x_reg + y_reg + z_reg;
        end
    end

    assign num_x = num_x_reg;
    assign num_y = num_y_reg;
    assign sum   = sum_reg;

endmodule

// ----- rtl/sxy_divider.sv -----
module sxy_divider
(
    input  logic                          clk,
    input  logic                          ce,
    input  logic [sxy_pkg::NUM_W-1:0]     num,
    input  logic [sxy_pkg::XYZ_W-1:0]     den,
    output logic [sxy_pkg::Q_W-1:0]       quot
);

    localparam int N = sxy_pkg::Q_W;

    logic [sxy_pkg::NUM_W-1:0] rem_reg [N];
    logic [sxy_pkg::XYZ_W-1:0] den_reg [N];
    logic [N-1:0]              q_reg   [N];

    // one quotient bit per stage, MSB first
    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic [sxy_pkg::NUM_W-1:0] rem_in;
        logic [sxy_pkg::XYZ_W-1:0] den_in;
        logic [N-1:0]              q_in;
        logic [sxy_pkg::NUM_W-1:0] shifted;
        logic                      take;

        if (k == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign q_in   = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        assign shifted = sxy_pkg::NUM_W'(den_in) << (N - 1 - k);
        assign take    = (rem_in >= shifted);

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rem_reg[k] <= take ? (rem_in - shifted) : rem_in;
                den_reg[k] <= den_in;
                q_reg[k]   <= q_in | (N'(take) << (N - 1 - k));
            end
        end
    end

    assign quot = (q_reg[N-1] > sxy_pkg::XY_MAX) ? sxy_pkg::XY_MAX : q_reg[N-1];

endmodule

// ----- rtl/srgb_to_cie_xy_core.sv -----
// sRGB to CIE 1931 xy chromaticity (D65). One transaction per clock in and
// out; the pipeline is a table decode, the matrix multiply and sum
// (four register stages) and a 16-stage restoring divider that yields one
// quotient bit per stage, then the output register. Backpressure on the
// master side stalls the whole pipeline; s_axis_tready follows it directly.
// Black input returns the default white point registers as written.
`include "srgb_to_cie_xy_core_macros.svh"

module srgb_to_cie_xy_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red, green, blue
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // chroma_x, chroma_y
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int LAT = sxy_pkg::MAT_LAT + sxy_pkg::DIV_LAT;

    logic                        ce;
    logic [LAT-1:0]              valid_reg;
    logic [LAT-1:0]              black_reg;
    logic                        out_valid_reg;
    logic [15:0]                 out_x_reg, out_y_reg;
    logic [15:0]                 white_x_reg, white_y_reg;
    logic [sxy_pkg::NUM_W-1:0]   num_x, num_y;
    logic [sxy_pkg::XYZ_W-1:0]   sum;
    logic [sxy_pkg::Q_W-1:0]     qx, qy;
    logic                        in_black;
    logic                        tail_black;

    assign ce            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = ce;
    assign in_black      = (s_axis_tdata == 24'd0);
    assign tail_black    = black_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            white_x_reg <= sxy_pkg::WHITE_X_RESET;
            white_y_reg <= sxy_pkg::WHITE_Y_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sxy_pkg::REG_WHITE_X: white_x_reg <= cfg_data;
                sxy_pkg::REG_WHITE_Y: white_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    sxy_matrix u_matrix
    (
        .clk   (clk),
        .ce    (ce),
        .red   (s_axis_tdata[7:0]),
        .green (s_axis_tdata[15:8]),
        .blue  (s_axis_tdata[23:16]),
        .num_x (num_x),
        .num_y (num_y),
        .sum   (sum)
    );

    sxy_divider u_div_x
    (
        .clk  (clk),
        .ce   (ce),
        .num  (num_x),
        .den  (sum),
        .quot (qx)
    );

    sxy_divider u_div_y
    (
        .clk  (clk),
        .ce   (ce),
        .num  (num_y),
        .den  (sum),
        .quot (qy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            valid_reg     <= {valid_reg[LAT-2:0], s_axis_tvalid};
            out_valid_reg <= valid_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            black_reg <= {black_reg[LAT-2:0], in_black};
            // zero sum only for black, still guarded
            if (tail_black || (qx == '0 && qy == '0 && valid_reg[LAT-1] && tail_black))
            begin
                out_x_reg <= white_x_reg;
                out_y_reg <= white_y_reg;
            end
            else
            begin
                out_x_reg <= qx;
                out_y_reg <= qy;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_y_reg, out_x_reg};

    `SXY_ASSERT_ALWAYS(a_ready_follows_out, s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    `SXY_ASSERT_IMPL(a_stall_holds, $past(m_axis_tvalid && !m_axis_tready), $stable(m_axis_tdata))
    `SXY_ASSERT_IMPL(a_range_x, m_axis_tvalid && $past(ce && !tail_black), m_axis_tdata[15:0] <= sxy_pkg::XY_MAX)

endmodule

// ----- dv/srgb_xy_checker.sv -----
module srgb_xy_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red, green, blue
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // chroma_x, chroma_y
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [351:0] wide_t;

    localparam longint unsigned LIN_SCALE = 65535;
    localparam longint unsigned CHROMA_MAX = 65279;

    // rows X, Y, Z; columns R, G, B; units of 1e-4
    localparam int unsigned MAT_E4 [9] = '{4124, 3576, 1805, 2126, 7152, 722, 193, 1192, 9505};

    logic [15:0]    srgb_decode [256];
    logic [15:0]    white_x;
    logic [15:0]    white_y;
    logic [31:0]    chroma_q [$];

    function automatic wide_t wide_pow(input longint unsigned b, input int n);
        wide_t acc;
        acc = 1;
        for (int i = 0; i < n; i++)
            acc = acc * wide_t'(b);
        return acc;
    endfunction

    // exact sRGB decode: largest e with ((2e-1)/(2S))^5 <= a^12 on the power segment
    initial
    begin
        wide_t          den_pow;
        wide_t          num_pow;
        wide_t          lhs;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        den_pow = wide_pow(269025, 12);
        for (int v = 0; v < 256; v++)
        begin
            if (v <= 10)
            begin
                srgb_decode[v] = 16'((20 * LIN_SCALE * v + 32946) / 65892);
            end
            else
            begin
                num_pow = wide_pow(1000 * v + 14025, 12) * wide_pow(2 * LIN_SCALE, 5);
                lo = 0;
                hi = LIN_SCALE;
                while (lo < hi)
                begin
                    mid = (lo + hi + 1) / 2;
                    lhs = den_pow * wide_pow(2 * mid - 1, 5);
                    if (lhs <= num_pow)
                        lo = mid;
                    else
                        hi = mid - 1;
                end
                srgb_decode[v] = 16'(lo);
            end
        end
    end

    function automatic longint unsigned coef_fix(input longint unsigned e4);
        return ((e4 << 16) + 5000) / 10000;
    endfunction

    function automatic logic [15:0] chroma_ratio(input longint unsigned part,
                                                 input longint unsigned total);
        longint unsigned q;
        q = (part * CHROMA_MAX) / total;
        return (q > CHROMA_MAX) ? 16'(CHROMA_MAX) : 16'(q);
    endfunction

    function automatic logic [31:0] predict_chroma(input logic [23:0] rgb);
        longint unsigned lin [3];
        longint unsigned xyz [3];
        longint unsigned total;
        if (rgb == '0)
            return {white_y, white_x};
        for (int c = 0; c < 3; c++)
            lin[c] = srgb_decode[rgb[c*sxy_pkg::CH_W +: sxy_pkg::CH_W]];
        for (int r = 0; r < 3; r++)
        begin
            xyz[r] = 0;
            for (int c = 0; c < 3; c++)
                xyz[r] += coef_fix(MAT_E4[r*3+c]) * lin[c];
        end
        total = xyz[0] + xyz[1] + xyz[2];
        if (total == 0)
            return {white_y, white_x};
        return {chroma_ratio(xyz[1], total), chroma_ratio(xyz[0], total)};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [31:0] want;
        if (!rst_n)
        begin
            white_x    <= sxy_pkg::WHITE_X_RESET;
            white_y    <= sxy_pkg::WHITE_Y_RESET;
            chroma_q.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_we && cfg_index == sxy_pkg::REG_WHITE_X)
                white_x <= cfg_data;
            if (cfg_we && cfg_index == sxy_pkg::REG_WHITE_Y)
                white_y <= cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                chroma_q.push_back(predict_chroma(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (chroma_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected transaction x=%0d y=%0d",
                                 m_axis_tdata[15:0], m_axis_tdata[31:16]);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = chroma_q.pop_front();
                    if (want !== m_axis_tdata)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: exp x=%0d y=%0d got x=%0d y=%0d",
                                     want[15:0], want[31:16],
                                     m_axis_tdata[15:0], m_axis_tdata[31:16]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= chroma_q.size();
        end
    end

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    int          fail_count;
    int          pending;
    logic        hold_req;
    logic        calm;
    int          cycles;

    srgb_to_cie_xy_core u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    srgb_xy_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 200000)
            begin
                $display("srgb_to_cie_xy_core verification failed");
                $finish;
            end
        end
    end

    // sink: random stalls, one long hold-off on request
    initial
    begin
        bit hold_done;
        hold_done = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1;
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 23);
        end
    end

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        if (!calm && $urandom_range(99) < 23)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, g, r};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    function automatic logic [7:0] rand_channel();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom_range(10));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic random_pixels(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(19) == 0)
                send_pixel(8'd0, 8'd0, 8'd0);
            else
                send_pixel(rand_channel(), rand_channel(), rand_channel());
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        hold_req      = 1'b0;
        calm          = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd1, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd1);
        send_pixel(8'd1, 8'd1, 8'd1);
        send_pixel(8'd10, 8'd10, 8'd10);
        send_pixel(8'd11, 8'd11, 8'd11);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd170, 8'd85, 8'd170);
        send_pixel(8'd85, 8'd170, 8'd85);
        send_pixel(8'd128, 8'd64, 8'd32);
        send_pixel(8'd0, 8'd0, 8'd0);
        drain();

        write_reg(2'd2, 16'hffff);
        write_reg(2'd3, 16'h1234);
        write_reg(sxy_pkg::REG_WHITE_X, 16'd0);
        write_reg(sxy_pkg::REG_WHITE_Y, 16'd65279);
        cfg_we <= 1'b0;
        send_pixel(8'd0, 8'd0, 8'd0);
        random_pixels(200);
        drain();

        write_reg(sxy_pkg::REG_WHITE_X, 16'd65279);
        write_reg(sxy_pkg::REG_WHITE_Y, 16'd0);
        cfg_we <= 1'b0;
        send_pixel(8'd0, 8'd0, 8'd0);
        hold_req <= 1'b1;
        random_pixels(100);
        calm <= 1'b1;
        random_pixels(100);
        calm <= 1'b0;
        drain();

        write_reg(sxy_pkg::REG_WHITE_X, 16'($urandom_range(65279)));
        write_reg(sxy_pkg::REG_WHITE_Y, 16'($urandom_range(65279)));
        cfg_we <= 1'b0;
        send_pixel(8'd0, 8'd0, 8'd0);
        random_pixels(230);
        drain();

        if (fail_count == 0)
            $display("srgb_to_cie_xy_core verification clean");
        else
            $display("srgb_to_cie_xy_core verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/sxy_pkg.sv
rtl/sxy_matrix.sv
rtl/sxy_divider.sv
rtl/srgb_to_cie_xy_core.sv
dv/srgb_xy_checker.sv
dv/tb_top.sv
